[hw/rtl/terminal_key_byte_decoder_top_assert.svh]
// Assertion macros shared by the decoder's checker files.
`ifndef TERMINAL_KEY_BYTE_DECODER_TOP_ASSERT_SVH
`define TERMINAL_KEY_BYTE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define TKD_ASSERT_HOLDS(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("terminal key decoder: same-cycle property failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define TKD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("terminal key decoder: next-cycle property failed");

`endif

[hw/rtl/tkd_pkg.sv]
// Shared types, codes and constants of the terminal key byte decoder.
package tkd_pkg;

  localparam int PARAM_MAX          = 15;
  localparam int PARAM_CAPACITY_DEF = 15;
  localparam int FILL_W             = 4;
  localparam int WAIT_W             = 16;
  localparam int QUEUE_DEPTH        = 2;
  localparam int QUEUE_PTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [WAIT_W-1:0] ESC_WAIT_RESET = 16'd100;

  localparam logic       MODE_BYTE = 1'b0;
  localparam logic       MODE_TICK = 1'b1;

  localparam logic [7:0]  BYTE_ESC       = 8'h1B;
  localparam logic [7:0]  BYTE_CSI_INTRO = 8'h5B;
  localparam logic [7:0]  BYTE_SS3_INTRO = 8'h4F;
  localparam logic [7:0]  BYTE_TAB       = 8'h09;
  localparam logic [7:0]  BYTE_LF        = 8'h0A;
  localparam logic [7:0]  BYTE_CR        = 8'h0D;
  localparam logic [7:0]  CTRL_LO        = 8'h01;
  localparam logic [7:0]  CTRL_HI        = 8'h1A;
  localparam logic [7:0]  CTRL_OFFSET    = 8'h40;
  localparam logic [7:0]  PRINT_LO       = 8'h20;
  localparam logic [7:0]  FINAL_LO       = 8'h40;
  localparam logic [7:0]  FINAL_HI       = 8'h7E;
  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_UTF8,
    PH_ESC,
    PH_CSI,
    PH_SS3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CHAR = 3'd0,
    KIND_CTRL = 3'd1,
    KIND_ALT  = 3'd2,
    KIND_CSI  = 3'd3,
    KIND_SS3  = 3'd4
  } kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [20:0] codepoint;
    logic [2:0]  utf8_len;
    logic [31:0] raw_bytes;
    logic [7:0]  key_code;
    logic        final_seen;
    logic [7:0]  final_code;
    logic [3:0]  param_count;
    logic [63:0] params_low;
    logic [55:0] params_high;
  } out_item_t;

  // Classified event passed from the front to the back through the queue.
  typedef struct packed {
    kind_t                  kind;
    logic                   err;
    logic [2:0]             count;
    logic [31:0]            raw;
    logic [7:0]             key;
    logic                   seen;
    logic [7:0]             fin;
    logic [FILL_W-1:0]      pcount;
    logic [PARAM_MAX*8-1:0] params;
  } req_t;

endpackage

[hw/rtl/tkd_front.sv]
// Front end: accepts input items, tracks sequence state and classifies events.
module tkd_front import tkd_pkg::*; #(
  parameter int PARAM_CAPACITY = PARAM_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  input  logic              cfg_wr_en,
  input  logic [WAIT_W-1:0] cfg_wr_data,
  input  logic              q_full,
  output logic              q_push,
  output req_t              q_req
);

  localparam int IDX_W = (PARAM_CAPACITY > 1) ? $clog2(PARAM_CAPACITY) : 1;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(PARAM_CAPACITY);

  phase_t            phase, phase_next;
  logic [2:0]        seq_expected, seq_expected_next;
  logic [2:0]        seq_received, seq_received_next;
  logic [31:0]       seq_bytes, seq_bytes_next;
  logic [WAIT_W-1:0] wait_counter, wait_counter_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [WAIT_W-1:0] escape_wait_ticks;
  logic [7:0]        param_store [PARAM_CAPACITY];

  logic                   accept;
  logic [7:0]             b;
  logic [WAIT_W-1:0]      wc_inc;
  logic [FILL_W-1:0]      fill_inc;
  logic [FILL_W-1:0]      fill_after;
  logic [2:0]             recv_inc;
  logic [31:0]            bytes_merged;
  logic                   csi_final;
  logic                   csi_store;
  logic [PARAM_MAX*8-1:0] params_cur;
  logic [2:0]             lead_len;
  logic                   is_ctrl;

  function automatic logic [2:0] lead_length(input logic [7:0] v);
    logic [2:0] n;
    if (v[7] == 1'b0)             n = 3'd1;
    else if (v[7:5] == 3'b110)    n = 3'd2;
    else if (v[7:4] == 4'b1110)   n = 3'd3;
    else if (v[7:3] == 5'b11110)  n = 3'd4;
    else                          n = 3'd0;
    return n;
  endfunction

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign b          = in_item.data_byte;
  assign wc_inc     = (wait_counter != '1) ? WAIT_W'(wait_counter + 1'b1) : wait_counter;
  assign fill_inc   = FILL_W'(fill + 1'b1);
  assign recv_inc   = 3'(seq_received + 3'd1);
  assign csi_final  = (b >= FINAL_LO) && (b <= FINAL_HI);
  assign csi_store  = (phase == PH_CSI) && (in_item.mode == MODE_BYTE) && !csi_final &&
                      (fill < FILL_LAST);
  assign fill_after = csi_store ? fill_inc : fill;
  assign lead_len   = lead_length(b);
  assign is_ctrl    = (b >= CTRL_LO) && (b <= CTRL_HI) && (b != BYTE_TAB) &&
                      (b != BYTE_LF) && (b != BYTE_CR);

  always_comb begin
    case (seq_received)
      3'd1:    bytes_merged = seq_bytes | {16'b0, b, 8'b0};
      3'd2:    bytes_merged = seq_bytes | {8'b0, b, 16'b0};
      3'd3:    bytes_merged = seq_bytes | {b, 24'b0};
      default: bytes_merged = seq_bytes;
    endcase
  end

  // Parameter bytes as they stand after this cycle's store.
  for (genvar i = 0; i < PARAM_MAX; i++) begin : g_params
    if (i < PARAM_CAPACITY) begin : g_live
      assign params_cur[8*i +: 8] =
        (csi_store && (fill == FILL_W'(i))) ? b : param_store[i];
    end else begin : g_pad
      assign params_cur[8*i +: 8] = 8'h00;
    end
  end

  always_comb begin
    phase_next        = phase;
    seq_expected_next = seq_expected;
    seq_received_next = seq_received;
    seq_bytes_next    = seq_bytes;
    wait_counter_next = wait_counter;
    fill_next         = fill;
    q_push            = 1'b0;
    q_req             = '0;
    q_req.kind        = KIND_CHAR;
    q_req.count       = 3'd1;

    if (accept) begin
      if (in_item.mode == MODE_TICK) begin
        case (phase)
          PH_UTF8: begin
            q_push      = 1'b1;
            q_req.err   = 1'b1;
            q_req.count = seq_expected;
            q_req.raw   = seq_bytes;
            phase_next  = PH_IDLE;
          end
          PH_ESC: begin
            wait_counter_next = wc_inc;
            if (wc_inc >= escape_wait_ticks) begin
              q_push     = 1'b1;
              q_req.raw  = {24'b0, BYTE_ESC};
              phase_next = PH_IDLE;
            end
          end
          PH_CSI: begin
            q_push       = 1'b1;
            q_req.kind   = KIND_CSI;
            q_req.pcount = fill;
            q_req.params = params_cur;
            phase_next   = PH_IDLE;
          end
          PH_SS3: begin
            q_push     = 1'b1;
            q_req.raw  = {24'b0, BYTE_ESC};
            phase_next = PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end else begin
        case (phase)
          PH_UTF8: begin
            if ((b[7:6] != 2'b10) || (seq_received >= 3'd4) ||
                (seq_received >= seq_expected)) begin
              // Bad continuation: report the bytes so far, drop this one.
              q_push      = 1'b1;
              q_req.err   = 1'b1;
              q_req.count = seq_expected;
              q_req.raw   = seq_bytes;
              phase_next  = PH_IDLE;
            end else begin
              seq_bytes_next    = bytes_merged;
              seq_received_next = recv_inc;
              if (recv_inc == seq_expected) begin
                q_push      = 1'b1;
                q_req.count = seq_expected;
                q_req.raw   = bytes_merged;
                phase_next  = PH_IDLE;
              end
            end
          end
          PH_ESC: begin
            if (b == BYTE_CSI_INTRO) begin
              phase_next = PH_CSI;
              fill_next  = '0;
            end else if (b == BYTE_SS3_INTRO) begin
              phase_next = PH_SS3;
            end else if ((b >= PRINT_LO) && (b <= FINAL_HI)) begin
              q_push     = 1'b1;
              q_req.kind = KIND_ALT;
              q_req.key  = b;
              phase_next = PH_IDLE;
            end else begin
              q_push     = 1'b1;
              q_req.raw  = {24'b0, BYTE_ESC};
              phase_next = PH_IDLE;
            end
          end
          PH_CSI: begin
            if (csi_final) begin
              q_push       = 1'b1;
              q_req.kind   = KIND_CSI;
              q_req.seen   = 1'b1;
              q_req.fin    = b;
              q_req.pcount = fill;
              q_req.params = params_cur;
              phase_next   = PH_IDLE;
            end else begin
              fill_next = fill_after;
              if (fill_after >= FILL_LAST) begin
                // Store full: close the sequence without a final byte.
                q_push       = 1'b1;
                q_req.kind   = KIND_CSI;
                q_req.pcount = fill_after;
                q_req.params = params_cur;
                phase_next   = PH_IDLE;
              end
            end
          end
          PH_SS3: begin
            q_push     = 1'b1;
            q_req.kind = KIND_SS3;
            q_req.fin  = b;
            phase_next = PH_IDLE;
          end
          default: begin
            phase_next = PH_IDLE;
            if (b == BYTE_ESC) begin
              phase_next        = PH_ESC;
              wait_counter_next = '0;
            end else if (lead_len == 3'd0) begin
              q_push    = 1'b1;
              q_req.err = 1'b1;
              q_req.raw = {24'b0, b};
            end else if (lead_len == 3'd1) begin
              q_push = 1'b1;
              if (is_ctrl) begin
                q_req.kind = KIND_CTRL;
                q_req.key  = 8'(b + CTRL_OFFSET);
              end else begin
                q_req.raw = {24'b0, b};
              end
            end else begin
              seq_expected_next = lead_len;
              seq_received_next = 3'd1;
              seq_bytes_next    = {24'b0, b};
              phase_next        = PH_UTF8;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      seq_expected      <= '0;
      seq_received      <= '0;
      seq_bytes         <= '0;
      wait_counter      <= '0;
      fill              <= '0;
      escape_wait_ticks <= ESC_WAIT_RESET;
    end else begin
      phase        <= phase_next;
      seq_expected <= seq_expected_next;
      seq_received <= seq_received_next;
      seq_bytes    <= seq_bytes_next;
      wait_counter <= wait_counter_next;
      fill         <= fill_next;
      if (cfg_wr_en) begin
        escape_wait_ticks <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && csi_store) begin
      param_store[fill[IDX_W-1:0]] <= b;
    end
  end

endmodule

[hw/rtl/tkd_queue.sv]
// Short request queue between the decoder front and back.
module tkd_queue import tkd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t req_in,
  output logic full,
  output logic valid,
  input  logic pop,
  output req_t req_out
);

  req_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full    = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign req_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QUEUE_PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QUEUE_PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= (QUEUE_PTR_W + 1)'(count + 1'b1);
      end else if (pop && !push) begin
        count <= (QUEUE_PTR_W + 1)'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= req_in;
    end
  end

endmodule

[hw/rtl/tkd_back.sv]
// Back end: turns queued requests into formatted key events in an output register.
module tkd_back import tkd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  output logic      q_pop,
  input  req_t      q_req,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t              fmt;
  logic [PARAM_MAX*8-1:0] params_masked;

  function automatic logic [20:0] assemble(input logic [2:0] n, input logic [31:0] r);
    logic [20:0] cp;
    case (n)
      3'd2:    cp = {10'b0, r[4:0], r[13:8]};
      3'd3:    cp = {5'b0, r[3:0], r[13:8], r[21:16]};
      3'd4:    cp = {r[2:0], r[13:8], r[21:16], r[29:24]};
      default: cp = CP_REPLACEMENT;
    endcase
    return cp;
  endfunction

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    params_masked = '0;
    for (int i = 0; i < PARAM_MAX; i++) begin
      if (FILL_W'(i) < q_req.pcount) begin
        params_masked[8*i +: 8] = q_req.params[8*i +: 8];
      end
    end
  end

  always_comb begin
    fmt            = '0;
    fmt.event_kind = q_req.kind;
    case (q_req.kind)
      KIND_CHAR: begin
        if (q_req.err) begin
          fmt.codepoint = CP_REPLACEMENT;
        end else if (q_req.count == 3'd1) begin
          fmt.codepoint = {13'b0, q_req.raw[7:0]};
        end else begin
          fmt.codepoint = assemble(q_req.count, q_req.raw);
        end
        fmt.utf8_len  = q_req.count;
        fmt.raw_bytes = q_req.raw;
      end
      KIND_CTRL, KIND_ALT: begin
        fmt.key_code = q_req.key;
      end
      KIND_CSI: begin
        fmt.final_seen  = q_req.seen;
        fmt.final_code  = q_req.fin;
        fmt.param_count = q_req.pcount;
        fmt.params_low  = params_masked[63:0];
        fmt.params_high = params_masked[PARAM_MAX*8-1:64];
      end
      KIND_SS3: begin
        fmt.final_code = q_req.fin;
      end
      default: fmt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item <= fmt;
    end
  end

endmodule

[hw/rtl/terminal_key_byte_decoder_top.sv]
// Top level of the terminal key byte decoder: front, request queue and back.
// Path: an accepted request's event is written into the queue, then into the output register.
// Throughput: one request per cycle while the queue has room; in_ready drops when it is full.
// Backpressure: the two-entry queue ahead of the output register absorbs stalls.
// Reset (rst, synchronous, active high) clears the decode phase, queue and output valid.
// Reset also sets the escape wait to 100 idle ticks.
module terminal_key_byte_decoder_top import tkd_pkg::*; #(
  parameter int PARAM_CAPACITY = PARAM_CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Input requests: a byte or one idle tick.
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  // Escape wait register; write it only while idle (the block itself does not enforce this).
  input  logic              cfg_wr_en,
  input  logic [WAIT_W-1:0] cfg_wr_data,
  // Key events.
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item
);

  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;
  req_t q_req_in;
  req_t q_req_out;

  // Front: accept a request whenever the queue has room, advance the
  // UTF-8 / escape phase and push at most one classified event.
  tkd_front #(
    .PARAM_CAPACITY(PARAM_CAPACITY)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_req      (q_req_in)
  );

  // Queue: hold classified events so the front keeps going while the
  // output side stalls.
  tkd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .req_in (q_req_in),
    .full   (q_full),
    .valid  (q_valid),
    .pop    (q_pop),
    .req_out(q_req_out)
  );

  // Back: assemble codepoints, zero fields that do not apply and drive
  // the registered output.
  tkd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_req    (q_req_out),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

[hw/rtl/tkd_checker.sv]
// Port-level checker for the terminal key byte decoder, bound to the top level.
`include "terminal_key_byte_decoder_top_assert.svh"

module tkd_checker import tkd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  logic is_char;
  logic is_csi;
  logic not_csi;
  logic final_ok;

  assign is_char  = out_valid && (out_item.event_kind == KIND_CHAR);
  assign is_csi   = out_valid && (out_item.event_kind == KIND_CSI);
  assign not_csi  = out_valid && (out_item.event_kind != KIND_CSI);
  assign final_ok = (out_item.final_code >= FINAL_LO) && (out_item.final_code <= FINAL_HI);

  `TKD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

  `TKD_ASSERT_HOLDS(a_kind_known, out_valid, out_item.event_kind <= KIND_SS3)

  `TKD_ASSERT_HOLDS(a_char_len, is_char, (out_item.utf8_len >= 3'd1) && (out_item.utf8_len <= 3'd4))

  `TKD_ASSERT_HOLDS(a_params_only_csi, not_csi, (out_item.param_count == '0) && !out_item.final_seen)

  `TKD_ASSERT_HOLDS(a_csi_final_range, is_csi && out_item.final_seen, final_ok)

endmodule

bind terminal_key_byte_decoder_top tkd_checker u_tkd_checker (.*);
